// ===== rtl/delay_trend_throughput_reporter_defines.svh =====
// assertion macros for the delay trend throughput reporter
// no dependencies; included by the top level, which carries the checks
`ifndef DELAY_TREND_THROUGHPUT_REPORTER_DEFINES_SVH
`define DELAY_TREND_THROUGHPUT_REPORTER_DEFINES_SVH

// plain property, sampled on clk, off during reset
`define DTTR_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define DTTR_CHECK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/dttr_pkg.sv =====
// shared types and constants for the delay trend throughput reporter
// no dependencies
`timescale 1ns / 1ps

package dttr_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int LS_SAMPLES_DEF = 8;

  localparam int BYTES_W  = 20;
  localparam int PERIOD_W = 16;
  localparam int RTT_W    = 16;
  localparam int MAXP_W   = 24;
  localparam int KBPS_W   = 31;
  localparam int KIND_W   = 2;

  localparam logic [KBPS_W-1:0] KBPS_MAX = {KBPS_W{1'b1}};

  localparam logic REQ_ACK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AUTH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TENT  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DATA,
    ST_MUL,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_A,
    ST_MUL_B,
    ST_REPORT,
    ST_NACK
  } state_t;

endpackage

// ===== rtl/dttr_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module dttr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dttr_div.sv =====
// restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps

module dttr_div #(
  parameter int N_W = 30,
  parameter int D_W = 23
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CW = $clog2(N_W + 1);

  logic [D_W-1:0] rem;
  logic [D_W:0]   trial;
  logic [D_W-1:0] dvs;
  logic [CW-1:0]  count;
  logic           run;
  logic           take;

  assign trial = {rem, quotient[N_W-1]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        count <= '0;
      end else if (run) begin
        count <= count + 1'b1;
        if (count == CW'(N_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (run) begin
      rem      <= take ? D_W'(trial - {1'b0, dvs}) : D_W'(trial);
      quotient <= {quotient[N_W-2:0], take};
    end
  end

endmodule

// ===== rtl/delay_trend_throughput_reporter.sv =====
// delay trend throughput reporter: top level
// depends on dttr_pkg, dttr_ram, dttr_div and delay_trend_throughput_reporter_defines.svh
//
// A send event or an invalid ack yields an empty result (report_kind 0,
// ack_valid 0) and stores nothing. A valid ack is written into the sample
// ring at acceptance, then the ring is walked back from the newest entry
// through the single ram read port: each of the newest LS_SAMPLES entries
// goes through read, load, multiply and accumulate steps, each older entry
// through read and load only, stopping early once the time sum passes
// max_period (0 means no limit). The throughput division then produces one
// quotient bit per cycle (BYTES_W + 3 + clog2(RING_DEPTH+1) bits), and the
// fit numerator and denominator products are formed in the MUL_A and MUL_B
// states. The next input word is taken once the result sits in the output
// register.
`timescale 1ns / 1ps
`include "delay_trend_throughput_reporter_defines.svh"

module delay_trend_throughput_reporter #(
  parameter int RING_DEPTH = dttr_pkg::RING_DEPTH_DEF,
  parameter int LS_SAMPLES = dttr_pkg::LS_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [dttr_pkg::MAXP_W-1:0]   cfg_wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic                          sample_valid,
  input  logic [dttr_pkg::BYTES_W-1:0]  sample_bytes,
  input  logic [dttr_pkg::PERIOD_W-1:0] sample_period_ms,
  input  logic [dttr_pkg::RTT_W-1:0]    sample_rtt_ms,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dttr_pkg::KIND_W-1:0]   report_kind,
  output logic [dttr_pkg::KBPS_W-1:0]   report_kbps,
  output logic                          ack_valid
);

  // ring geometry
  localparam int AW     = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int ENT_W  = dttr_pkg::BYTES_W + dttr_pkg::PERIOD_W + dttr_pkg::RTT_W;
  // throughput sums
  localparam int BYTE_W = dttr_pkg::BYTES_W + CNT_W;
  localparam int TIME_W = dttr_pkg::PERIOD_W + CNT_W;
  localparam int DVD_W  = BYTE_W + 3;
  // least-squares sums
  localparam int FC_W   = $clog2(LS_SAMPLES + 1);
  localparam int X_W    = dttr_pkg::PERIOD_W + FC_W;
  localparam int SX_W   = X_W + FC_W;
  localparam int SY_W   = dttr_pkg::RTT_W + FC_W;
  localparam int SXY_W  = X_W + dttr_pkg::RTT_W + FC_W;
  localparam int SXX_W  = 2 * X_W + FC_W;
  localparam int PXY_W  = SXY_W + FC_W;
  localparam int PXX_W  = SXX_W + FC_W;

  dttr_pkg::state_t state, state_next;

  // configuration
  logic [dttr_pkg::MAXP_W-1:0] max_period;

  // ring bookkeeping
  logic [AW-1:0]    newest_slot;
  logic [CNT_W-1:0] stored_count;
  logic [AW-1:0]    wr_slot;
  logic             in_acc;
  logic             ack_ok;

  // walk state
  logic [AW-1:0]    walk_ptr;
  logic [CNT_W-1:0] walk_idx;
  logic [CNT_W-1:0] walk_idx_next;
  logic [BYTE_W-1:0] byte_total;
  logic [TIME_W-1:0] time_total;
  logic [TIME_W-1:0] time_total_next;
  logic             walk_more;
  logic             in_fit;

  // fit state
  logic [FC_W-1:0]  fit_cnt;
  logic [X_W-1:0]   xcum;
  logic [dttr_pkg::RTT_W-1:0] ycur;
  logic [X_W+dttr_pkg::RTT_W-1:0] prod_xy;
  logic [2*X_W-1:0] prod_xx;
  logic [SX_W-1:0]  sx;
  logic [SY_W-1:0]  sy;
  logic [SXY_W-1:0] sxy;
  logic [SXX_W-1:0] sxx;
  logic [PXY_W-1:0] p_xy_n;   // sxy * n
  logic [PXY_W-1:0] p_x_y;    // sx * sy
  logic [PXX_W-1:0] p_xx_n;   // sxx * n
  logic [PXX_W-1:0] p_x_x;    // sx * sx

  // ram
  logic             ram_we;
  logic             ram_re;
  logic [ENT_W-1:0] ram_rdata;
  logic [dttr_pkg::BYTES_W-1:0]  rd_bytes;
  logic [dttr_pkg::PERIOD_W-1:0] rd_period;
  logic [dttr_pkg::RTT_W-1:0]    rd_rtt;

  // divider
  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;

  // report
  logic [dttr_pkg::KBPS_W-1:0] last_kbps;
  logic [dttr_pkg::KBPS_W-1:0] tp;
  logic                        fit_full;
  logic                        slope_neg;
  logic [dttr_pkg::KIND_W-1:0] kind_calc;
  logic                        out_free;
  logic                        out_load;

  assign in_acc   = in_valid && !in_stall;
  assign ack_ok   = (req_type == dttr_pkg::REQ_ACK) && sample_valid;
  // first sample goes into the current slot, later ones advance it
  assign wr_slot  = (stored_count == '0) ? newest_slot :
                    (newest_slot == AW'(RING_DEPTH - 1)) ? '0 : newest_slot + 1'b1;
  assign out_free = !out_valid || !out_stall;

  assign {rd_bytes, rd_period, rd_rtt} = ram_rdata;

  dttr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_slot),
    .wdata ({sample_bytes, sample_period_ms, sample_rtt_ms}),
    .re    (ram_re),
    .raddr (walk_ptr),
    .rdata (ram_rdata)
  );

  dttr_div #(
    .N_W (DVD_W),
    .D_W (TIME_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({byte_total, 3'b000}),
    .divisor  (time_total),
    .done     (div_done),
    .quotient (div_quo)
  );

  // walk step: totals grow on the load cycle, the index moves there too
  assign in_fit          = 32'(walk_idx) < LS_SAMPLES;
  assign time_total_next = (state == dttr_pkg::ST_DATA) ?
                           time_total + TIME_W'(rd_period) : time_total;
  assign walk_idx_next   = (state == dttr_pkg::ST_DATA) ? walk_idx + 1'b1 : walk_idx;
  assign walk_more       = (walk_idx_next < stored_count) &&
                           ((max_period == '0) ||
                            (32'(time_total_next) <= 32'(max_period)));

  // throughput, zero on an empty time window, saturated to the port width
  always_comb begin
    if (time_total == '0) begin
      tp = '0;
    end else if (64'(div_quo) > 64'(dttr_pkg::KBPS_MAX)) begin
      tp = dttr_pkg::KBPS_MAX;
    end else begin
      tp = dttr_pkg::KBPS_W'(div_quo);
    end
  end

  // negative slope: den > 0 and num < 0, both as compares of nonnegative products
  assign fit_full  = 32'(fit_cnt) >= LS_SAMPLES;
  assign slope_neg = (p_xx_n > p_x_x) && (p_xy_n < p_x_y);

  always_comb begin
    kind_calc = dttr_pkg::KIND_NONE;
    if (fit_full) begin
      if (slope_neg) begin
        if (tp != last_kbps) begin
          kind_calc = dttr_pkg::KIND_AUTH;
        end
      end else if (tp > last_kbps) begin
        kind_calc = dttr_pkg::KIND_TENT;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dttr_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = ack_ok ? dttr_pkg::ST_READ : dttr_pkg::ST_NACK;
        end
      end
      dttr_pkg::ST_READ: state_next = dttr_pkg::ST_DATA;
      dttr_pkg::ST_DATA: begin
        if (in_fit) begin
          state_next = dttr_pkg::ST_MUL;
        end else begin
          state_next = walk_more ? dttr_pkg::ST_READ : dttr_pkg::ST_DIV_GO;
        end
      end
      dttr_pkg::ST_MUL: state_next = dttr_pkg::ST_SUM;
      dttr_pkg::ST_SUM: state_next = walk_more ? dttr_pkg::ST_READ : dttr_pkg::ST_DIV_GO;
      dttr_pkg::ST_DIV_GO: state_next = dttr_pkg::ST_DIV_WAIT;
      dttr_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = dttr_pkg::ST_MUL_A;
        end
      end
      dttr_pkg::ST_MUL_A: state_next = dttr_pkg::ST_MUL_B;
      dttr_pkg::ST_MUL_B: state_next = dttr_pkg::ST_REPORT;
      dttr_pkg::ST_REPORT, dttr_pkg::ST_NACK: begin
        if (out_free) begin
          state_next = dttr_pkg::ST_IDLE;
        end
      end
      default: state_next = dttr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      dttr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ram_we   = in_acc && ack_ok;
      end
      dttr_pkg::ST_READ:   ram_re    = 1'b1;
      dttr_pkg::ST_DIV_GO: div_start = 1'b1;
      dttr_pkg::ST_REPORT, dttr_pkg::ST_NACK: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dttr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_period <= '0;
    end else if (cfg_wr_en) begin
      max_period <= cfg_wr_data;
    end
  end

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      newest_slot  <= '0;
      stored_count <= '0;
    end else if (ram_we) begin
      newest_slot <= wr_slot;
      if (32'(stored_count) < RING_DEPTH) begin
        stored_count <= stored_count + 1'b1;
      end
    end
  end

  // walk and fit datapath
  always_ff @(posedge clk) begin
    case (state)
      dttr_pkg::ST_IDLE: begin
        walk_ptr   <= wr_slot;
        walk_idx   <= '0;
        byte_total <= '0;
        time_total <= '0;
        fit_cnt    <= '0;
        xcum       <= '0;
        sx         <= '0;
        sy         <= '0;
        sxy        <= '0;
        sxx        <= '0;
      end
      dttr_pkg::ST_DATA: begin
        byte_total <= byte_total + BYTE_W'(rd_bytes);
        time_total <= time_total_next;
        walk_idx   <= walk_idx_next;
        walk_ptr   <= (walk_ptr == '0) ? AW'(RING_DEPTH - 1) : walk_ptr - 1'b1;
        if (in_fit) begin
          fit_cnt <= fit_cnt + 1'b1;
          xcum    <= xcum + X_W'(rd_period);
          ycur    <= rd_rtt;
        end
      end
      dttr_pkg::ST_MUL: begin
        prod_xy <= xcum * ycur;
        prod_xx <= xcum * xcum;
      end
      dttr_pkg::ST_SUM: begin
        sx  <= sx + SX_W'(xcum);
        sy  <= sy + SY_W'(ycur);
        sxy <= sxy + SXY_W'(prod_xy);
        sxx <= sxx + SXX_W'(prod_xx);
      end
      dttr_pkg::ST_MUL_A: begin
        p_xy_n <= PXY_W'(sxy) * PXY_W'(fit_cnt);
        p_xx_n <= PXX_W'(sxx) * PXX_W'(fit_cnt);
      end
      dttr_pkg::ST_MUL_B: begin
        p_x_y <= PXY_W'(sx) * PXY_W'(sy);
        p_x_x <= PXX_W'(sx) * PXX_W'(sx);
      end
      default: ;
    endcase
  end

  // output register and last reported value
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_kbps <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (out_load && (state == dttr_pkg::ST_REPORT) &&
          (kind_calc != dttr_pkg::KIND_NONE)) begin
        last_kbps <= tp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == dttr_pkg::ST_REPORT) begin
        report_kind <= kind_calc;
        report_kbps <= (kind_calc != dttr_pkg::KIND_NONE) ? tp : '0;
        ack_valid   <= fit_full;
      end else begin
        report_kind <= dttr_pkg::KIND_NONE;
        report_kbps <= '0;
        ack_valid   <= 1'b0;
      end
    end
  end

  // checks
  `DTTR_CHECK_IMP(a_report_needs_full_fit, out_valid && (report_kind != dttr_pkg::KIND_NONE), ack_valid, "report without full fit window")
  `DTTR_CHECK_IMP(a_walk_within_ring, state == dttr_pkg::ST_DATA, walk_idx < stored_count, "walk passed stored samples")
  `DTTR_CHECK(a_fit_bounded, 32'(fit_cnt) <= LS_SAMPLES, "fit count above window")
  `DTTR_CHECK_IMP(a_last_tracks_report, out_valid && (report_kind != dttr_pkg::KIND_NONE), last_kbps == report_kbps, "last reported value out of step")

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for delay_trend_throughput_reporter
// drives random and table-driven send/ack words and checks against a local predictor
// depends on dttr_pkg and the reporter rtl
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = dttr_pkg::RING_DEPTH_DEF;
  localparam int FIT_N = dttr_pkg::LS_SAMPLES_DEF;
  localparam int LIMIT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [dttr_pkg::MAXP_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic sample_valid = 1'b0;
  logic [dttr_pkg::BYTES_W-1:0] sample_bytes = '0;
  logic [dttr_pkg::PERIOD_W-1:0] sample_period_ms = '0;
  logic [dttr_pkg::RTT_W-1:0] sample_rtt_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [dttr_pkg::KIND_W-1:0] report_kind;
  logic [dttr_pkg::KBPS_W-1:0] report_kbps;
  logic ack_valid;

  always #5 clk = ~clk;

  delay_trend_throughput_reporter u_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .sample_valid(sample_valid),
    .sample_bytes(sample_bytes), .sample_period_ms(sample_period_ms),
    .sample_rtt_ms(sample_rtt_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .report_kind(report_kind), .report_kbps(report_kbps), .ack_valid(ack_valid)
  );

  // one ack or send word
  typedef struct packed {
    logic                          kind;
    logic                          ok;
    logic [dttr_pkg::BYTES_W-1:0]  bytes;
    logic [dttr_pkg::PERIOD_W-1:0] period;
    logic [dttr_pkg::RTT_W-1:0]    rtt;
  } word_t;

  // one report word
  typedef struct packed {
    logic [dttr_pkg::KIND_W-1:0] rkind;
    logic [dttr_pkg::KBPS_W-1:0] kbps;
    logic                        full;
  } report_t;

  // predictor state: mirror of the sample ring and report history
  logic [dttr_pkg::BYTES_W-1:0]  ring_bytes [DEPTH];
  logic [dttr_pkg::PERIOD_W-1:0] ring_period [DEPTH];
  logic [dttr_pkg::RTT_W-1:0]    ring_rtt [DEPTH];
  int unsigned head_slot, fill_count;
  logic [dttr_pkg::KBPS_W-1:0] last_kbps;
  logic [dttr_pkg::MAXP_W-1:0] window_ms;

  report_t report_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0, recv_idle = 0;   // idle percentages

  function automatic report_t predict_report(word_t w);
    report_t r;
    longint unsigned byte_sum, time_sum, xcum, tput;
    longint sxy, sx, sy, sxx, num, den, y, xs;
    int unsigned i, idx, n;
    bit falling;
    r = '0;
    byte_sum = 0; time_sum = 0; xcum = 0;
    sxy = 0; sx = 0; sy = 0; sxx = 0; n = 0;
    if (w.kind != dttr_pkg::REQ_ACK || !w.ok) return r;
    if (fill_count > 0) head_slot = (head_slot + 1) % DEPTH;
    ring_bytes[head_slot] = w.bytes;
    ring_period[head_slot] = w.period;
    ring_rtt[head_slot] = w.rtt;
    if (fill_count < DEPTH) fill_count++;
    for (i = 0; i < fill_count && (time_sum <= window_ms || window_ms == 0); i++) begin
      idx = (head_slot + DEPTH - i) % DEPTH;
      byte_sum += ring_bytes[idx];
      time_sum += ring_period[idx];
      if (i < FIT_N) begin
        n++;
        xcum += ring_period[idx];
        xs = longint'(xcum);
        y = longint'(ring_rtt[idx]);
        sxy += xs * y; sx += xs; sy += y; sxx += xs * xs;
      end
    end
    if (time_sum == 0) tput = 0;
    else begin
      tput = (byte_sum * 8) / time_sum;
      if (tput > dttr_pkg::KBPS_MAX) tput = dttr_pkg::KBPS_MAX;
    end
    num = sxy * longint'(n) - sx * sy;
    den = sxx * longint'(n) - sx * sx;
    falling = (den > 0) && (num < 0);
    if (n >= FIT_N) begin
      if (falling) begin
        if (tput[dttr_pkg::KBPS_W-1:0] != last_kbps) begin
          last_kbps = tput[dttr_pkg::KBPS_W-1:0];
          r.rkind = dttr_pkg::KIND_AUTH; r.kbps = last_kbps;
        end
      end else if (tput[dttr_pkg::KBPS_W-1:0] > last_kbps) begin
        last_kbps = tput[dttr_pkg::KBPS_W-1:0];
        r.rkind = dttr_pkg::KIND_TENT; r.kbps = last_kbps;
      end
      r.full = 1'b1;
    end
    return r;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall, check at rising edge
  always @(negedge clk) out_stall <= !rst && ($urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    report_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        $error("report with nothing expected");
        errors++;
      end else begin
        exp_r = report_q.pop_front();
        if (report_kind !== exp_r.rkind) begin
          $error("report_kind exp %0d got %0d", exp_r.rkind, report_kind); errors++;
        end
        if (report_kbps !== exp_r.kbps) begin
          $error("report_kbps exp %0d got %0d", exp_r.kbps, report_kbps); errors++;
        end
        if (ack_valid !== exp_r.full) begin
          $error("ack_valid exp %0d got %0d", exp_r.full, ack_valid); errors++;
        end
      end
    end
  end

  // push one word through the input channel; optional typed-in expectation
  // valid stays up after acceptance until the next word or an idle cycle
  task automatic send_word(word_t w, bit has_exp = 0, report_t known = '0);
    report_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {req_type, sample_valid, sample_bytes, sample_period_ms, sample_rtt_ms} <= w;
    r = predict_report(w);
    if (has_exp && r !== known) begin
      $error("table row disagrees: exp %h predicted %h", known, r); errors++;
    end
    report_q.push_back(r);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_window(logic [dttr_pkg::MAXP_W-1:0] v);
    cfg_wr_en <= 1'b1; cfg_wr_data <= v;
    window_ms = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic word_t ack_word(logic [dttr_pkg::BYTES_W-1:0] b,
                                     logic [dttr_pkg::PERIOD_W-1:0] p,
                                     logic [dttr_pkg::RTT_W-1:0] d);
    return {dttr_pkg::REQ_ACK, 1'b1, b, p, d};
  endfunction

  // random word: mostly valid acks with trends, some sends and bad acks
  function automatic word_t rand_word(int unsigned pos);
    word_t w;
    int unsigned sel;
    sel = $urandom_range(99);
    w.kind = (sel < 8) ? ~dttr_pkg::REQ_ACK : dttr_pkg::REQ_ACK;
    w.ok = (sel >= 8 && sel < 14) ? 1'b0 : 1'b1;
    case ($urandom_range(3))
      0: w.bytes = dttr_pkg::BYTES_W'($urandom);
      1: w.bytes = dttr_pkg::BYTES_W'($urandom_range(3000));
      default: w.bytes = dttr_pkg::BYTES_W'($urandom_range(200000));
    endcase
    case ($urandom_range(4))
      0: w.period = dttr_pkg::PERIOD_W'($urandom);
      1: w.period = '0;
      default: w.period = dttr_pkg::PERIOD_W'($urandom_range(1, 200));
    endcase
    // delay trending down or up in stretches, with noise
    if ((pos / 20) % 2 == 0) w.rtt = 16'(4000 - (pos % 20) * 50 + $urandom_range(30));
    else if ($urandom_range(3) == 0) w.rtt = dttr_pkg::RTT_W'($urandom);
    else w.rtt = 16'(1000 + (pos % 20) * 40 + $urandom_range(30));
    return w;
  endfunction

  // directed table: row word, and whether a result is typed in
  word_t   dir_word [21];
  bit      dir_has  [21];
  report_t dir_exp  [21];

  initial begin
    int unsigned k, phase, n_items;
    logic [dttr_pkg::MAXP_W-1:0] windows [4];
    head_slot = 0; fill_count = 0; last_kbps = '0; window_ms = '0;
    for (k = 0; k < 21; k++) begin
      dir_has[k] = 0; dir_exp[k] = '0;
    end
    // send event and invalid ack: empty results, nothing stored
    dir_word[0] = {~dttr_pkg::REQ_ACK, 1'b1, {dttr_pkg::BYTES_W{1'b1}}, 16'hffff, 16'hffff};
    dir_has[0] = 1;
    dir_word[1] = {dttr_pkg::REQ_ACK, 1'b0, {dttr_pkg::BYTES_W{1'b1}}, 16'hffff, 16'hffff};
    dir_has[1] = 1;
    // first valid ack: fit window not full yet
    dir_word[2] = ack_word('0, '0, '0);
    dir_has[2] = 1;
    // falling delay with extreme bytes and 1 ms periods, high rate
    for (k = 3; k < 10; k++) begin
      dir_word[k] = ack_word({dttr_pkg::BYTES_W{1'b1}}, 16'd1, 16'(9000 - k * 1000));
    end
    for (k = 3; k < 9; k++) dir_has[k] = 1;
    // rising delay, large periods
    for (k = 10; k < 18; k++) dir_word[k] = ack_word(20'(k * 1000), 16'hffff, 16'(k * 100));
    // flat delay: zero denominator only when periods are zero
    for (k = 18; k < 21; k++) dir_word[k] = ack_word(20'd5, 16'd0, 16'd77);

    n_items = 0;
    windows[0] = 24'hffffff; windows[1] = 24'd1; windows[2] = 24'd300; windows[3] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_window('0);
    for (k = 0; k < 21; k++) send_word(dir_word[k], dir_has[k], dir_exp[k]);
    drain();

    // three idling phases, several window settings within each
    for (phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 35 : (phase == 1) ? 88 : 0;
      recv_idle = (phase == 0) ? 88 : (phase == 1) ? 35 : 0;
      for (k = 0; k < 4; k++) begin
        write_window(windows[(k + phase) % 4]);
        repeat (145) begin
          send_word(rand_word(n_items));
          n_items++;
          // hold the sender until everything has drained once
          if (n_items == 300) begin
            in_valid <= 1'b0;
            while (report_q.size() != 0) @(negedge clk);
          end
        end
        drain();
      end
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // typed-in expectations for the directed rows
  initial begin
    dir_exp[0] = '0;
    dir_exp[1] = '0;
    dir_exp[2] = '0;
    for (int j = 3; j < 9; j++) dir_exp[j] = '0;
  end

endmodule
